// ===== hdl/esc_pkg.sv =====
// Shared types and constants of the environmental sensor compensation block.
package esc_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int DIV_STEPS = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CALIB       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CALIB_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CALIB_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIXED_CALIB      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HUM_CALIB        = 3'd4;

	localparam logic [24:0] PRESS_MAX = 25'h1FFFFFF;
	localparam logic [31:0] HUM_LIMIT = 32'd419430400;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [15:0] h4;
		logic [15:0] h5;
		logic [7:0]  h6;
	} calib_t;

	typedef struct packed {
		logic [19:0] adc_temperature;
		logic [19:0] adc_pressure;
		logic [15:0] adc_humidity;
	} sample_t;

	typedef struct packed {
		logic [63:0] num_mag;
		logic [30:0] den_mag;
		logic        qneg;
		logic        zero;
	} press_op_t;

	typedef struct packed {
		press_op_t   op;
		logic [15:0] temp;
		logic [16:0] hum;
		logic        tclamp;
	} div_in_t;

	typedef struct packed {
		logic [15:0] temperature_centi;
		logic [24:0] pressure_q24_8;
		logic [16:0] humidity_q22_10;
		logic        clamped;
	} result_t;

endpackage

// ===== hdl/esc_in_if.sv =====
// Input channel: one raw temperature, pressure and humidity item.
interface esc_in_if;
	logic        valid;
	logic        ready;
	logic [19:0] adc_temperature;
	logic [19:0] adc_pressure;
	logic [15:0] adc_humidity;

	modport source (output valid, output adc_temperature, output adc_pressure,
		output adc_humidity, input ready);
	modport sink (input valid, input adc_temperature, input adc_pressure,
		input adc_humidity, output ready);
endinterface

// ===== hdl/esc_out_if.sv =====
// Output channel: one compensated result item.
interface esc_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] temperature_centi;
	logic [24:0]        pressure_q24_8;
	logic [16:0]        humidity_q22_10;
	logic               clamped;

	modport source (output valid, output temperature_centi, output pressure_q24_8,
		output humidity_q22_10, output clamped, input ready);
	modport sink (input valid, input temperature_centi, input pressure_q24_8,
		input humidity_q22_10, input clamped, output ready);
endinterface

// ===== hdl/env_sensor_compensation.sv =====
// Top level of the environmental sensor compensation block.
//
//  channel   dir   handshake            payload
//  sample    in    valid/ready          adc_temperature, adc_pressure, adc_humidity
//  result    out   valid/ready          temperature_centi, pressure_q24_8,
//                                       humidity_q22_10, clamped
//  cfg       in    cfg_wr_en            cfg_index, cfg_data
//
//  One item per cycle when not stalled; 13 front stages, 64 divider stages
//  (one quotient bit per stage), 6 correction stages and the output register.
//  Reset clears all valid bits and the calibration registers.
//  The pipeline stalls only when its last stage holds an item and the output
//  register holds one that is not taken; nothing moves during a stall.
module env_sensor_compensation (
	input  logic                          clk,
	input  logic                          arst_n,
	esc_in_if.sink                        sample,
	esc_out_if.source                     result,
	input  logic                          cfg_wr_en,
	input  logic [esc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);

	esc_pkg::calib_t  calib;
	esc_pkg::sample_t smp;
	esc_pkg::div_in_t front_data;
	esc_pkg::result_t div_data;
	esc_pkg::result_t res_q;
	logic front_vld, div_vld, res_vld_q;
	logic out_load, en;

	assign out_load = !res_vld_q || result.ready;
	assign en       = out_load || !div_vld;

	assign smp.adc_temperature = sample.adc_temperature;
	assign smp.adc_pressure    = sample.adc_pressure;
	assign smp.adc_humidity    = sample.adc_humidity;
	assign sample.ready        = en;

	esc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.calib  (calib)
	);

	esc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sample.valid),
		.in_data   (smp),
		.calib     (calib),
		.out_valid (front_vld),
		.out_data  (front_data)
	);

	esc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_vld),
		.in_data   (front_data),
		.calib     (calib),
		.out_valid (div_vld),
		.out_data  (div_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (out_load) begin
			res_vld_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= div_data;
		end
	end

	assign result.valid             = res_vld_q;
	assign result.temperature_centi = res_q.temperature_centi;
	assign result.pressure_q24_8    = res_q.pressure_q24_8;
	assign result.humidity_q22_10   = res_q.humidity_q22_10;
	assign result.clamped           = res_q.clamped;

endmodule

// ===== hdl/esc_cfg.sv =====
// Calibration registers and coefficient unpacking.
module esc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [esc_pkg::CFG_IDX_W-1:0]  index,
	input  logic [63:0]                    data,
	output esc_pkg::calib_t                calib
);

	logic [47:0] temp_calib_q;
	logic [63:0] press_calib_low_q;
	logic [63:0] press_calib_high_q;
	logic [47:0] mixed_calib_q;
	logic [39:0] hum_calib_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q       <= '0;
			press_calib_low_q  <= '0;
			press_calib_high_q <= '0;
			mixed_calib_q      <= '0;
			hum_calib_q        <= '0;
		end else if (wr_en) begin
			unique case (index)
				esc_pkg::CFG_TEMP_CALIB:       temp_calib_q       <= data[47:0];
				esc_pkg::CFG_PRESS_CALIB_LOW:  press_calib_low_q  <= data;
				esc_pkg::CFG_PRESS_CALIB_HIGH: press_calib_high_q <= data;
				esc_pkg::CFG_MIXED_CALIB:      mixed_calib_q      <= data[47:0];
				esc_pkg::CFG_HUM_CALIB:        hum_calib_q        <= data[39:0];
				default: ;
			endcase
		end
	end

	assign calib.t1 = temp_calib_q[15:0];
	assign calib.t2 = temp_calib_q[31:16];
	assign calib.t3 = temp_calib_q[47:32];
	assign calib.p1 = press_calib_low_q[15:0];
	assign calib.p2 = press_calib_low_q[31:16];
	assign calib.p3 = press_calib_low_q[47:32];
	assign calib.p4 = press_calib_low_q[63:48];
	assign calib.p5 = press_calib_high_q[15:0];
	assign calib.p6 = press_calib_high_q[31:16];
	assign calib.p7 = press_calib_high_q[47:32];
	assign calib.p8 = press_calib_high_q[63:48];
	assign calib.p9 = mixed_calib_q[15:0];
	assign calib.h1 = mixed_calib_q[23:16];
	assign calib.h2 = mixed_calib_q[39:24];
	assign calib.h3 = mixed_calib_q[47:40];
	assign calib.h4 = hum_calib_q[15:0];
	assign calib.h5 = hum_calib_q[31:16];
	assign calib.h6 = hum_calib_q[39:32];

endmodule

// ===== hdl/esc_front.sv =====
// Front pipeline: temperature, humidity and pressure divide operands, 13 stages.
module esc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  esc_pkg::sample_t  in_data,
	input  esc_pkg::calib_t   calib,
	output logic              out_valid,
	output esc_pkg::div_in_t  out_data
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <= '0;
			{vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13} <= '0;
		end else if (en) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	assign out_valid = vld_s13;

	// stage 1
	logic signed [17:0] e1;
	logic signed [16:0] d1;
	logic signed [33:0] m1, dd1;
	logic [31:0] v1p_s1, dd_s1;
	logic [19:0] adc_p_s1, adc_p_s2, adc_p_s3, adc_p_s4, adc_p_s5, adc_p_s6;
	logic [15:0] adc_h_s1, adc_h_s2, adc_h_s3, adc_h_s4;

	assign e1  = $signed({1'b0, in_data.adc_temperature[19:3]}) - $signed({1'b0, calib.t1, 1'b0});
	assign d1  = $signed({1'b0, in_data.adc_temperature[19:4]}) - $signed({1'b0, calib.t1});
	assign m1  = e1 * $signed(calib.t2);
	assign dd1 = d1 * d1;

	// stage 2
	logic signed [19:0] dd12;
	logic signed [35:0] m2;
	logic [31:0] v1s_s2, m2_s2;

	assign dd12 = $signed(dd_s1[31:12]);
	assign m2   = dd12 * $signed(calib.t3);

	// stage 3
	logic [31:0] tf;
	logic [32:0] a3;
	logic [31:0] tfine_s3, x_s3;
	logic [32:0] a_s3;

	assign tf = v1s_s2 + {{14{m2_s2[31]}}, m2_s2[31:14]};
	assign a3 = {tf[31], tf} - 33'd128000;

	// stage 4
	logic [31:0] t5;
	logic signed [23:0] tv;
	logic [15:0] temp4;
	logic tcl4;
	logic signed [65:0] aa4;
	logic signed [48:0] ap5_4, ap2_4;
	logic signed [47:0] h5x4;
	logic signed [39:0] xh6_4;
	logic signed [40:0] xh3_4;
	logic [15:0] temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9;
	logic [15:0] temp_s10, temp_s11, temp_s12;
	logic tcl_s4, tcl_s5, tcl_s6, tcl_s7, tcl_s8, tcl_s9, tcl_s10, tcl_s11, tcl_s12;
	logic [63:0] aa_s4;
	logic [48:0] ap5_s4, ap2_s4;
	logic [31:0] h5x_s4, xh6_s4, xh3_s4;

	assign t5 = {tfine_s3[29:0], 2'b00} + tfine_s3 + 32'd128;
	assign tv = $signed(t5[31:8]);

	always_comb begin
		tcl4 = 1'b0;
		priority if (tv > 24'sd32767) begin
			temp4 = 16'h7FFF;
			tcl4  = 1'b1;
		end else if (tv < -24'sd32768) begin
			temp4 = 16'h8000;
			tcl4  = 1'b1;
		end else begin
			temp4 = tv[15:0];
		end
	end

	assign aa4   = $signed(a_s3) * $signed(a_s3);
	assign ap5_4 = $signed(a_s3) * $signed(calib.p5);
	assign ap2_4 = $signed(a_s3) * $signed(calib.p2);
	assign h5x4  = $signed(x_s3) * $signed(calib.h5);
	assign xh6_4 = $signed(x_s3) * $signed(calib.h6);
	assign xh3_4 = $signed(x_s3) * $signed({1'b0, calib.h3});

	// stage 5
	logic signed [79:0] aap6_5, aap3_5;
	logic [31:0] hsum5;
	logic [63:0] aap6_s5, aap3_s5, pre_s5;
	logic [48:0] ap2_s5;
	logic [31:0] hp_s5, hb_s5, hc_s5;

	assign aap6_5 = $signed(aa_s4) * $signed(calib.p6);
	assign aap3_5 = $signed(aa_s4) * $signed(calib.p3);
	assign hsum5  = {2'b00, adc_h_s4, 14'd0} - {calib.h4[11:0], 20'd0} - h5x_s4 + 32'd16384;

	// stage 6
	logic signed [63:0] hbc6;
	logic [63:0] bb_s6, a2_s6;
	logic [31:0] hbc_s6, hp_s6;

	assign hbc6 = $signed(hb_s5) * $signed(hc_s5);

	// stage 7
	logic [20:0] pval7;
	logic [63:0] diff_s7, a2p_s7;
	logic [31:0] hd_s7, hp_s7;

	assign pval7 = 21'd1048576 - {1'b0, adc_p_s6};

	// stage 8
	logic [75:0] num8;
	logic [79:0] m8;
	logic signed [47:0] hdh2_8;
	logic [63:0] num_s8, m_s8;
	logic [31:0] hdh2_s8, hp_s8;

	assign num8   = diff_s7 * 12'd3125;
	assign m8     = a2p_s7 * calib.p1;
	assign hdh2_8 = $signed(hd_s7) * $signed(calib.h2);

	// stage 9
	esc_pkg::press_op_t op9;
	logic [31:0] hs9;
	esc_pkg::press_op_t op_s9, op_s10, op_s11, op_s12;
	logic [31:0] he_s9, hp_s9;

	always_comb begin
		op9.num_mag = num_s8[63] ? 64'd0 - num_s8 : num_s8;
		op9.den_mag = m_s8[63] ? 31'd0 - m_s8[63:33] : m_s8[63:33];
		op9.qneg    = num_s8[63] ^ m_s8[63];
		op9.zero    = (m_s8[63:33] == 31'd0);
	end
	assign hs9 = hdh2_s8 + 32'd8192;

	// stage 10
	logic signed [63:0] hx10;
	logic [31:0] hx_s10, hx_s11, hx_s12;

	assign hx10 = $signed(hp_s9) * $signed(he_s9);

	// stage 11
	logic signed [33:0] sq11;
	logic [31:0] sq_s11;

	assign sq11 = $signed(hx_s10[31:15]) * $signed(hx_s10[31:15]);

	// stage 12
	logic signed [33:0] sh12;
	logic [31:0] sh1_s12;

	assign sh12 = $signed(sq_s11[31:7]) * $signed({1'b0, calib.h1});

	// stage 13
	logic [31:0] hf13, hs13;

	assign hf13 = hx_s12 - {{4{sh1_s12[31]}}, sh1_s12[31:4]};

	always_comb begin
		priority if (hf13[31]) begin
			hs13 = 32'd0;
		end else if (hf13 > esc_pkg::HUM_LIMIT) begin
			hs13 = esc_pkg::HUM_LIMIT;
		end else begin
			hs13 = hf13;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v1p_s1   <= m1[31:0];
			dd_s1    <= dd1[31:0];
			adc_p_s1 <= in_data.adc_pressure;
			adc_h_s1 <= in_data.adc_humidity;

			v1s_s2   <= {{11{v1p_s1[31]}}, v1p_s1[31:11]};
			m2_s2    <= m2[31:0];
			adc_p_s2 <= adc_p_s1;
			adc_h_s2 <= adc_h_s1;

			tfine_s3 <= tf;
			a_s3     <= a3;
			x_s3     <= tf - 32'd76800;
			adc_p_s3 <= adc_p_s2;
			adc_h_s3 <= adc_h_s2;

			temp_s4  <= temp4;
			tcl_s4   <= tcl4;
			aa_s4    <= aa4[63:0];
			ap5_s4   <= ap5_4;
			ap2_s4   <= ap2_4;
			h5x_s4   <= h5x4[31:0];
			xh6_s4   <= xh6_4[31:0];
			xh3_s4   <= xh3_4[31:0];
			adc_p_s4 <= adc_p_s3;
			adc_h_s4 <= adc_h_s3;

			aap6_s5  <= aap6_5[63:0];
			aap3_s5  <= aap3_5[63:0];
			pre_s5   <= {ap5_s4[46:0], 17'd0} + {{13{calib.p4[15]}}, calib.p4, 35'd0};
			ap2_s5   <= ap2_s4;
			hp_s5    <= {{15{hsum5[31]}}, hsum5[31:15]};
			hb_s5    <= {{10{xh6_s4[31]}}, xh6_s4[31:10]};
			hc_s5    <= {{11{xh3_s4[31]}}, xh3_s4[31:11]} + 32'd32768;
			temp_s5  <= temp_s4;
			tcl_s5   <= tcl_s4;
			adc_p_s5 <= adc_p_s4;

			bb_s6    <= aap6_s5 + pre_s5;
			a2_s6    <= {{8{aap3_s5[63]}}, aap3_s5[63:8]} + {{3{ap2_s5[48]}}, ap2_s5, 12'd0};
			hbc_s6   <= hbc6[31:0];
			hp_s6    <= hp_s5;
			temp_s6  <= temp_s5;
			tcl_s6   <= tcl_s5;
			adc_p_s6 <= adc_p_s5;

			diff_s7  <= {12'd0, pval7, 31'd0} - bb_s6;
			a2p_s7   <= a2_s6 + 64'h0000_8000_0000_0000;
			hd_s7    <= {{10{hbc_s6[31]}}, hbc_s6[31:10]} + 32'd2097152;
			hp_s7    <= hp_s6;
			temp_s7  <= temp_s6;
			tcl_s7   <= tcl_s6;

			num_s8   <= num8[63:0];
			m_s8     <= m8[63:0];
			hdh2_s8  <= hdh2_8[31:0];
			hp_s8    <= hp_s7;
			temp_s8  <= temp_s7;
			tcl_s8   <= tcl_s7;

			op_s9    <= op9;
			he_s9    <= {{14{hs9[31]}}, hs9[31:14]};
			hp_s9    <= hp_s8;
			temp_s9  <= temp_s8;
			tcl_s9   <= tcl_s8;

			hx_s10   <= hx10[31:0];
			op_s10   <= op_s9;
			temp_s10 <= temp_s9;
			tcl_s10  <= tcl_s9;

			sq_s11   <= sq11[31:0];
			hx_s11   <= hx_s10;
			op_s11   <= op_s10;
			temp_s11 <= temp_s10;
			tcl_s11  <= tcl_s10;

			sh1_s12  <= sh12[31:0];
			hx_s12   <= hx_s11;
			op_s12   <= op_s11;
			temp_s12 <= temp_s11;
			tcl_s12  <= tcl_s11;

			out_data.op     <= op_s12;
			out_data.temp   <= temp_s12;
			out_data.hum    <= hs13[28:12];
			out_data.tclamp <= tcl_s12;
		end
	end

endmodule

// ===== hdl/esc_div.sv =====
// Pressure back end: 64-stage signed divider, correction terms and saturation.
module esc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  esc_pkg::div_in_t  in_data,
	input  esc_pkg::calib_t   calib,
	output logic              out_valid,
	output esc_pkg::result_t  out_data
);

	typedef struct packed {
		logic        zero;
		logic [15:0] temp;
		logic [16:0] hum;
		logic        tclamp;
	} side_t;

	typedef struct packed {
		logic [30:0] rem;
		logic [63:0] nq;
		logic [30:0] dv;
		logic        qneg;
		side_t       sd;
	} dstage_t;

	function automatic dstage_t div_step(dstage_t s);
		logic [31:0] trial;
		logic [31:0] diff;
		logic        ge;
		dstage_t     r;
		trial = {s.rem, s.nq[63]};
		diff  = trial - {1'b0, s.dv};
		ge    = (trial >= {1'b0, s.dv});
		r     = s;
		r.rem = ge ? diff[30:0] : trial[30:0];
		r.nq  = {s.nq[62:0], ge};
		return r;
	endfunction

	dstage_t init;
	dstage_t nxt [esc_pkg::DIV_STEPS];
	dstage_t dst_s [esc_pkg::DIV_STEPS];
	logic [esc_pkg::DIV_STEPS-1:0] dvld_s;

	always_comb begin
		init.rem       = '0;
		init.nq        = in_data.op.num_mag;
		init.dv        = in_data.op.den_mag;
		init.qneg      = in_data.op.qneg;
		init.sd.zero   = in_data.op.zero;
		init.sd.temp   = in_data.temp;
		init.sd.hum    = in_data.hum;
		init.sd.tclamp = in_data.tclamp;
		nxt[0] = div_step(init);
		for (int k = 1; k < esc_pkg::DIV_STEPS; k++) begin
			nxt[k] = div_step(dst_s[k-1]);
		end
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_s <= '0;
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6} <= '0;
		end else if (en) begin
			dvld_s <= {dvld_s[esc_pkg::DIV_STEPS-2:0], in_valid};
			vld_s1 <= dvld_s[esc_pkg::DIV_STEPS-1];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// correction terms
	dstage_t last;
	logic [63:0] p_s1, p_s2, p_s3, p_s4;
	side_t sd_s1, sd_s2, sd_s3, sd_s4, sd_s5;
	logic [63:0] ps2;
	logic [63:0] ll2, lh2;
	logic signed [79:0] pp8_2, c1_4;
	logic [63:0] ll_s2, pp8_s2, pp8_s3, pp8_s4, pp_s3, c1r_s4, s_s5;
	logic [31:0] lh_s2;
	logic [63:0] r6;
	logic [24:0] press6;
	logic pcl6;

	assign last  = dst_s[esc_pkg::DIV_STEPS-1];
	assign ps2   = {{13{p_s1[63]}}, p_s1[63:13]};
	assign ll2   = ps2[31:0] * ps2[31:0];
	assign lh2   = ps2[31:0] * ps2[63:32];
	assign pp8_2 = $signed(p_s1) * $signed(calib.p8);
	assign c1_4  = $signed(pp_s3) * $signed(calib.p9);
	assign r6    = {{8{s_s5[63]}}, s_s5[63:8]} + {{44{calib.p7[15]}}, calib.p7, 4'd0};

	always_comb begin
		pcl6 = 1'b0;
		priority if (sd_s5.zero) begin
			press6 = '0;
		end else if (r6[63]) begin
			press6 = '0;
			pcl6   = 1'b1;
		end else if (r6 > {39'd0, esc_pkg::PRESS_MAX}) begin
			press6 = esc_pkg::PRESS_MAX;
			pcl6   = 1'b1;
		end else begin
			press6 = r6[24:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dst_s <= nxt;

			p_s1   <= last.qneg ? 64'd0 - last.nq : last.nq;
			sd_s1  <= last.sd;

			ll_s2  <= ll2;
			lh_s2  <= lh2[31:0];
			pp8_s2 <= pp8_2[63:0];
			p_s2   <= p_s1;
			sd_s2  <= sd_s1;

			pp_s3  <= ll_s2 + {lh_s2[30:0], 33'd0};
			pp8_s3 <= pp8_s2;
			p_s3   <= p_s2;
			sd_s3  <= sd_s2;

			c1r_s4 <= c1_4[63:0];
			pp8_s4 <= pp8_s3;
			p_s4   <= p_s3;
			sd_s4  <= sd_s3;

			s_s5   <= p_s4 + {{25{c1r_s4[63]}}, c1r_s4[63:25]}
				+ {{19{pp8_s4[63]}}, pp8_s4[63:19]};
			sd_s5  <= sd_s4;

			out_data.temperature_centi <= sd_s5.temp;
			out_data.pressure_q24_8    <= press6;
			out_data.humidity_q22_10   <= sd_s5.hum;
			out_data.clamped           <= sd_s5.tclamp | pcl6;
		end
	end

	assign out_valid = vld_s6;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		dvld_s[esc_pkg::DIV_STEPS-1] |-> (last.rem < last.dv) || (last.dv == 31'd0))
		else $error("divider remainder not below divisor");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(dvld_s) && $stable(vld_s6))
		else $error("pipeline valid bits moved during stall");

	a_valid_travels: assert property (@(posedge clk) disable iff (!arst_n)
		en && dvld_s[esc_pkg::DIV_STEPS-1] |=> vld_s1)
		else $error("item lost leaving divider");

endmodule
